>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CCCV_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cccv checker: assertion failed");

// Implication in the next cycle, built on the macro above.
`define CCCV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    `CCCV_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

>>> design/cccv_pkg.sv
package cccv_pkg;

    localparam int DUTY_TOP       = 19;
    localparam int SETTLE_SAMPLES = 5;
    localparam int DIV_NUM_W      = 26;
    localparam int DIV_DEN_W      = 13;
    localparam int DIV_CNT_W      = 5;
    localparam int MUL_A_W        = 16;
    localparam int MUL_B_W        = 12;
    localparam int MUL_CNT_W      = 4;
    localparam int PROD_W         = MUL_A_W + MUL_B_W;
    localparam int MAS_PER_MAH    = 3600;

    localparam logic [1:0] CFG_VOLT_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_START_LIMIT = 2'd1;
    localparam logic [1:0] CFG_DISCHARGE   = 2'd2;

    typedef enum logic [3:0] {
        PH_NONE    = 4'd0,
        PH_REST    = 4'd1,
        PH_RAMP    = 4'd2,
        PH_RES     = 4'd3,
        PH_CHG     = 4'd4,
        PH_DONE    = 4'd5,
        PH_DIS     = 4'd6,
        PH_DISDONE = 4'd7,
        PH_RAMP2   = 4'd8,
        PH_REST2   = 4'd9,
        PH_RES2    = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CALC = 2'd1,
        ST_UPD  = 2'd2
    } t_state;

    // Multiply by 1000 as 1024 - 16 - 8.
    function automatic logic [DIV_NUM_W-1:0] times_1000(input logic [15:0] x);
        logic [DIV_NUM_W-1:0] w;
        w = {{(DIV_NUM_W-16){1'b0}}, x};
        return (w << 10) - (w << 4) - (w << 3);
    endfunction

endpackage

>>> design/cccv_div.sv
// Restoring divider, one quotient bit per cycle.
module cccv_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cccv_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [cccv_pkg::DIV_DEN_W-1:0] i_den,
    output logic [cccv_pkg::DIV_NUM_W-1:0] o_quo,
    output logic                           o_busy
);
    logic [cccv_pkg::DIV_NUM_W-1:0] r_q;
    logic [cccv_pkg::DIV_DEN_W-1:0] r_rem;
    logic [cccv_pkg::DIV_DEN_W-1:0] r_den;
    logic [cccv_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic [cccv_pkg::DIV_DEN_W:0]   w_trial;
    logic [cccv_pkg::DIV_DEN_W:0]   w_diff;

    assign w_trial = {r_rem, r_q[cccv_pkg::DIV_NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= cccv_pkg::DIV_CNT_W'(cccv_pkg::DIV_NUM_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_diff[cccv_pkg::DIV_DEN_W-1:0];
                r_q   <= {r_q[cccv_pkg::DIV_NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[cccv_pkg::DIV_DEN_W-1:0];
                r_q   <= {r_q[cccv_pkg::DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_q;
    assign o_busy = r_busy;
endmodule

>>> design/cccv_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
module cccv_mul (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic [cccv_pkg::MUL_A_W-1:0]               i_a,
    input  logic [cccv_pkg::MUL_B_W-1:0]               i_b,
    output logic [cccv_pkg::PROD_W-1:0]                o_prod,
    output logic                                       o_busy
);
    logic [cccv_pkg::PROD_W-1:0]        r_acc;
    logic [cccv_pkg::PROD_W-1:0]        r_a;
    logic [cccv_pkg::MUL_B_W-1:0]       r_b;
    logic [cccv_pkg::MUL_CNT_W-1:0]     r_cnt;
    logic                               r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= cccv_pkg::MUL_CNT_W'(cccv_pkg::MUL_B_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= {{cccv_pkg::MUL_B_W{1'b0}}, i_a};
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_prod = r_acc;
    assign o_busy = r_busy;
endmodule

>>> design/cc_cv_charger_sequencer.sv
// An accepted input transaction starts the serial divider and multiplier; the block waits in the
// calculate state until both finish, then loads the output register once it is free or being read.
// The input is ready again only after that load, so one transaction is handled at a time.
// The voltage limit check uses a serial multiplier running beside the divider.
// A new transaction is taken while a finished result still waits in the output register.
// Reset (synchronous, active low) returns the no-battery phase and reset register values.
module cc_cv_charger_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [13:0] i_voltage_mv,
    input  logic [11:0] i_current_ma,
    input  logic        i_second_tick,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_duty_out,
    output logic [2:0]  o_phase,
    output logic [15:0] o_resistance_mohm,
    output logic [11:0] o_limit_now_ma,
    output logic [15:0] o_charge_mah,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);
    cccv_pkg::t_state r_state, n_state;

    logic [13:0] r_volt_limit;
    logic [11:0] r_start_limit;
    logic        r_discharge;

    cccv_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_duty, n_duty;
    logic [4:0]  r_ramp, n_ramp;
    logic [13:0] r_rest, n_rest;
    logic [14:0] r_sumv, n_sumv;
    logic [12:0] r_sumc, n_sumc;
    logic        r_avg, n_avg;
    logic [15:0] r_res, n_res;
    logic [11:0] r_wl, n_wl;
    logic [2:0]  r_settle, n_settle;
    logic [15:0] r_mah, n_mah;
    logic [11:0] r_mas, n_mas;

    logic [13:0] r_v;
    logic [11:0] r_c;
    logic        r_tick;
    logic        r_rose;
    logic        r_czero;

    logic        r_out_valid;
    logic [4:0]  r_o_duty;
    logic [2:0]  r_o_phase;
    logic [15:0] r_o_res;
    logic [11:0] r_o_wl;
    logic [15:0] r_o_mah;

    logic        w_in_acc;
    logic        w_load;
    logic [15:0] w_sumv_new;
    logic [14:0] w_base;
    logic [12:0] w_sumc_new;
    logic [15:0] w_vdiff;
    logic [cccv_pkg::DIV_NUM_W-1:0] w_quo;
    logic        w_div_busy;
    logic [cccv_pkg::PROD_W-1:0] w_prod;
    logic        w_mul_busy;
    logic [15:0] w_calc_res;
    logic [cccv_pkg::DIV_NUM_W-1:0] w_over1000;
    logic        w_over;
    logic [2:0]  w_shown;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == cccv_pkg::ST_IDLE);

    // Resistance operands are formed from the sums as they stand after this sample.
    assign w_sumv_new = {2'b0, i_voltage_mv} + {1'b0, r_sumv};
    assign w_base     = {r_rest, 1'b0};
    assign w_sumc_new = r_sumc + {1'b0, i_current_ma};
    assign w_vdiff    = w_sumv_new - {1'b0, w_base};

    cccv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_num   (cccv_pkg::times_1000(w_vdiff)),
        .i_den   (w_sumc_new),
        .o_quo   (w_quo),
        .o_busy  (w_div_busy)
    );

    cccv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_a     (r_res),
        .i_b     (i_current_ma),
        .o_prod  (w_prod),
        .o_busy  (w_mul_busy)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_v     <= i_voltage_mv;
            r_c     <= i_current_ma;
            r_tick  <= i_second_tick;
            r_rose  <= (w_sumv_new > {1'b0, w_base});
            r_czero <= (w_sumc_new == '0);
        end
    end

    always_comb begin
        if (!r_rose) begin
            w_calc_res = '0;
        end else if (r_czero) begin
            w_calc_res = 16'hFFFF;
        end else if (w_quo[cccv_pkg::DIV_NUM_W-1:16] != '0) begin
            w_calc_res = 16'hFFFF;
        end else begin
            w_calc_res = w_quo[15:0];
        end
    end

    // v*1000 > limit*1000 + R*I holds only when v exceeds the limit.
    assign w_over1000 = cccv_pkg::times_1000({2'b0, r_v - r_volt_limit});
    assign w_over = (r_v > r_volt_limit) &&
                    ({{(cccv_pkg::PROD_W-cccv_pkg::DIV_NUM_W){1'b0}}, w_over1000} > w_prod);

    always_comb begin
        logic        fin;
        logic [12:0] mas;
        logic [15:0] mah;
        n_phase  = r_phase;
        n_duty   = r_duty;
        n_ramp   = r_ramp;
        n_rest   = r_rest;
        n_sumv   = r_sumv;
        n_sumc   = r_sumc;
        n_avg    = r_avg;
        n_res    = r_res;
        n_wl     = r_wl;
        n_settle = r_settle;
        fin      = 1'b0;

        mas = {1'b0, r_mas} + {1'b0, r_c};
        mah = r_mah;
        if (r_tick) begin
            if (mas >= 13'(cccv_pkg::MAS_PER_MAH)) begin
                mas = mas - 13'(cccv_pkg::MAS_PER_MAH);
                if (mah != 16'hFFFF) mah = mah + 1'b1;
            end
            if (mas >= 13'(cccv_pkg::MAS_PER_MAH)) begin
                mas = mas - 13'(cccv_pkg::MAS_PER_MAH);
                if (mah != 16'hFFFF) mah = mah + 1'b1;
            end
            n_mas = mas[11:0];
        end else begin
            n_mas = r_mas;
        end
        n_mah = mah;

        if (r_discharge) begin
            if (n_phase != cccv_pkg::PH_DIS && n_phase != cccv_pkg::PH_DISDONE) begin
                n_phase = cccv_pkg::PH_DIS;
                n_duty  = '0;
                n_ramp  = '0;
            end
            if (n_phase != cccv_pkg::PH_DISDONE) begin
                if (r_v < 14'd1000) begin
                    n_phase = cccv_pkg::PH_DISDONE;
                    n_duty  = '0;
                end else if (n_ramp < 5'(cccv_pkg::DUTY_TOP - 1)) begin
                    n_ramp = n_ramp + 1'b1;
                    n_duty = (n_duty >= 5'(cccv_pkg::DUTY_TOP)) ?
                             5'(cccv_pkg::DUTY_TOP) : n_duty + 1'b1;
                end
            end
        end else begin
            if (n_phase == cccv_pkg::PH_DIS || n_phase == cccv_pkg::PH_DISDONE ||
                n_phase > cccv_pkg::PH_RES2) begin
                n_phase = cccv_pkg::PH_NONE;
                n_duty  = '0;
            end
            if (r_v < 14'd500 || r_v > 14'd10000) begin
                n_phase  = cccv_pkg::PH_NONE;
                n_duty   = '0;
                n_ramp   = '0;
                n_settle = '0;
                n_avg    = 1'b0;
            end else begin
                case (n_phase)
                    cccv_pkg::PH_NONE: begin
                        if (r_v > 14'd800 && r_v < 14'd9000) begin
                            n_phase = cccv_pkg::PH_REST;
                            n_wl    = r_start_limit;
                        end
                    end
                    cccv_pkg::PH_REST: begin
                        n_rest  = r_v;
                        n_phase = cccv_pkg::PH_RAMP;
                        n_ramp  = '0;
                    end
                    cccv_pkg::PH_REST2: begin
                        n_rest  = r_v;
                        n_phase = cccv_pkg::PH_RES2;
                        n_avg   = 1'b0;
                    end
                    cccv_pkg::PH_RAMP, cccv_pkg::PH_RAMP2: begin
                        if (r_c < n_wl) begin
                            n_duty = (n_duty >= 5'(cccv_pkg::DUTY_TOP)) ?
                                     5'(cccv_pkg::DUTY_TOP) : n_duty + 1'b1;
                        end else if (r_c > n_wl) begin
                            if (n_duty != '0) begin
                                n_duty = n_duty - 1'b1;
                                fin    = 1'b1;
                            end else begin
                                n_duty = 5'd1;
                            end
                        end
                        n_ramp = n_ramp + 1'b1;
                        if (n_ramp >= 5'(cccv_pkg::DUTY_TOP - 1)) fin = 1'b1;
                        if (fin) begin
                            n_ramp = '0;
                            if (n_phase == cccv_pkg::PH_RAMP) begin
                                n_phase = cccv_pkg::PH_RES;
                                n_avg   = 1'b0;
                            end else begin
                                n_phase  = cccv_pkg::PH_CHG;
                                n_settle = '0;
                            end
                        end
                    end
                    cccv_pkg::PH_RES, cccv_pkg::PH_RES2: begin
                        if (!n_avg) begin
                            n_sumv = {1'b0, r_v};
                            n_sumc = {1'b0, r_c};
                            n_avg  = 1'b1;
                        end else begin
                            n_sumv = r_sumv + {1'b0, r_v};
                            n_sumc = r_sumc + {1'b0, r_c};
                            n_avg  = 1'b0;
                            n_res  = w_calc_res;
                            if (n_phase == cccv_pkg::PH_RES2) begin
                                n_phase  = cccv_pkg::PH_CHG;
                                n_settle = '0;
                            end else if (w_calc_res > 16'd1500 && n_duty > 5'd3) begin
                                if (n_wl > 12'd200) n_wl = n_wl - 12'd100;
                                n_phase = cccv_pkg::PH_REST;
                            end else begin
                                n_duty  = 5'd1;
                                n_ramp  = '0;
                                n_phase = cccv_pkg::PH_RAMP2;
                            end
                        end
                    end
                    cccv_pkg::PH_CHG: begin
                        if (n_duty == '0) begin
                            n_phase = cccv_pkg::PH_DONE;
                        end else if (n_settle < 3'(cccv_pkg::SETTLE_SAMPLES)) begin
                            n_settle = n_settle + 1'b1;
                        end else if (r_c < 12'd80) begin
                            n_phase = cccv_pkg::PH_DONE;
                            n_duty  = '0;
                        end else if (w_over) begin
                            n_duty   = n_duty - 1'b1;
                            n_settle = '0;
                            n_phase  = (n_duty == '0) ? cccv_pkg::PH_DONE :
                                       cccv_pkg::PH_REST2;
                        end
                    end
                    cccv_pkg::PH_DONE: begin
                    end
                    default: begin
                        n_phase = cccv_pkg::PH_NONE;
                        n_duty  = '0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (n_phase)
            cccv_pkg::PH_RAMP2: w_shown = 3'(cccv_pkg::PH_RAMP);
            cccv_pkg::PH_REST2: w_shown = 3'(cccv_pkg::PH_REST);
            cccv_pkg::PH_RES2:  w_shown = 3'(cccv_pkg::PH_RES);
            cccv_pkg::PH_NONE, cccv_pkg::PH_REST, cccv_pkg::PH_RAMP, cccv_pkg::PH_RES,
            cccv_pkg::PH_CHG, cccv_pkg::PH_DONE, cccv_pkg::PH_DIS,
            cccv_pkg::PH_DISDONE: w_shown = n_phase[2:0];
            default:            w_shown = 3'(cccv_pkg::PH_NONE);
        endcase
    end

    assign w_load = (r_state == cccv_pkg::ST_UPD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            cccv_pkg::ST_IDLE: if (w_in_acc) n_state = cccv_pkg::ST_CALC;
            cccv_pkg::ST_CALC: if (!w_div_busy && !w_mul_busy) n_state = cccv_pkg::ST_UPD;
            cccv_pkg::ST_UPD:  if (w_load) n_state = cccv_pkg::ST_IDLE;
            default:           n_state = cccv_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cccv_pkg::ST_IDLE;
            r_volt_limit  <= 14'd7100;
            r_start_limit <= 12'd1200;
            r_discharge   <= 1'b0;
            r_phase       <= cccv_pkg::PH_NONE;
            r_duty        <= '0;
            r_ramp        <= '0;
            r_rest        <= '0;
            r_sumv        <= '0;
            r_sumc        <= '0;
            r_avg         <= 1'b0;
            r_res         <= '0;
            r_wl          <= 12'd1200;
            r_settle      <= '0;
            r_mah         <= '0;
            r_mas         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cccv_pkg::CFG_VOLT_LIMIT:  r_volt_limit  <= i_cfg_data;
                    cccv_pkg::CFG_START_LIMIT: r_start_limit <= i_cfg_data[11:0];
                    cccv_pkg::CFG_DISCHARGE:   r_discharge   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (w_load) begin
                r_phase     <= n_phase;
                r_duty      <= n_duty;
                r_ramp      <= n_ramp;
                r_rest      <= n_rest;
                r_sumv      <= n_sumv;
                r_sumc      <= n_sumc;
                r_avg       <= n_avg;
                r_res       <= n_res;
                r_wl        <= n_wl;
                r_settle    <= n_settle;
                r_mah       <= n_mah;
                r_mas       <= n_mas;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_duty  <= (w_shown == 3'(cccv_pkg::PH_NONE) ||
                          w_shown == 3'(cccv_pkg::PH_REST) ||
                          w_shown == 3'(cccv_pkg::PH_DONE) ||
                          w_shown == 3'(cccv_pkg::PH_DISDONE)) ? 5'd0 : n_duty;
            r_o_phase <= w_shown;
            r_o_res   <= n_res;
            r_o_wl    <= n_wl;
            r_o_mah   <= n_mah;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_duty_out        = r_o_duty;
    assign o_phase           = r_o_phase;
    assign o_resistance_mohm = r_o_res;
    assign o_limit_now_ma    = r_o_wl;
    assign o_charge_mah      = r_o_mah;
endmodule

>>> design/cccv_checker.sv
`include "assert_macros.svh"

module cccv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  o_duty_out,
    input logic [2:0]  o_phase
);
    logic       w_in_acc;
    logic       w_out_wait;
    logic [7:0] w_out_word;
    logic       w_idle_phase;

    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_out_wait   = o_out_valid && !i_out_ready;
    assign w_out_word   = {o_duty_out, o_phase};
    assign w_idle_phase = o_out_valid &&
                          (o_phase == 3'(cccv_pkg::PH_NONE) ||
                           o_phase == 3'(cccv_pkg::PH_REST) ||
                           o_phase == 3'(cccv_pkg::PH_DONE) ||
                           o_phase == 3'(cccv_pkg::PH_DISDONE));

    // The block works on one transaction at a time.
    `CCCV_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_in_acc, !o_in_ready)
    // A waiting result is held until taken.
    `CCCV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_out_valid && $stable(w_out_word))
    // Idle phases drive no duty.
    `CCCV_ASSERT(a_idle_duty, i_clk, i_rst_n, w_idle_phase |-> (o_duty_out == 5'd0))
endmodule

bind cc_cv_charger_sequencer cccv_checker u_cccv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_duty_out  (o_duty_out),
    .o_phase     (o_phase)
);
